// ===== hw/rtl/baob_pkg.sv =====
// Shared types and constants for the brush alpha-over blender.
package baob_pkg;

   localparam int CoordWidth = 9;
   localparam int NumWidth   = 24;

   typedef enum logic [1:0] {
      ACT_LOAD  = 2'd0,
      ACT_BLEND = 2'd1,
      ACT_READ  = 2'd2,
      ACT_NONE  = 2'd3
   } act_type;

   typedef enum logic [1:0] {
      CSR_TEX_WIDTH  = 2'd0,
      CSR_TEX_HEIGHT = 2'd1,
      CSR_OFFSET_X   = 2'd2,
      CSR_OFFSET_Y   = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] pos_x;
      logic [7:0] pos_y;
      logic [7:0] in_red;
      logic [7:0] in_green;
      logic [7:0] in_blue;
      logic [7:0] in_alpha;
   } req_type;

   typedef struct packed {
      logic [7:0] out_x;
      logic [7:0] out_y;
      logic [7:0] out_red;
      logic [7:0] out_green;
      logic [7:0] out_blue;
      logic [7:0] out_alpha;
   } rsp_type;

   typedef struct packed {
      logic                  vld;
      act_type               act;
      logic [CoordWidth-1:0] x;
      logic [CoordWidth-1:0] y;
   } ctl_type;

endpackage

// ===== hw/rtl/brush_alpha_over_blender_unit.sv =====
// Top level: RGBA8 texel store with pipelined Porter-Duff over blending.
//
// Usage:
//   Items enter on start/req_data when busy is low. action selects load,
//   blend or read of a texel. Loads return nothing; in-range reads and
//   blends return one item each on rsp_valid/rsp_data.
//   Items outside the texture (or action 3) return nothing.
//   Throughput is one item per cycle while busy is low. busy rises only
//   when a new read or blend targets a texel that an earlier load or
//   blend in the 12-stage pipeline has yet to write back; it then holds
//   until that write lands.
//   The store is one memory, read at pipeline entry and written at the
//   last stage; the blend divides with a one-bit-per-stage restoring
//   divider (8 stages).
//   csr_we/csr_index/csr_wdata set texture size and brush offset; write
//   them only while the block is idle.
//   Reset (synchronous) clears the pipeline and restores the registers to
//   256x256 and zero offset. The store holds whatever it held; texels must
//   be loaded before they are read or blended.
//   Results are strobed for one cycle; the receiver cannot stall them.
module brush_alpha_over_blender_unit #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  baob_pkg::req_type        req_data,
   output logic                     rsp_valid,
   output baob_pkg::rsp_type        rsp_data,
   input  logic                     csr_we,
   input  baob_pkg::csr_index_type  csr_index,
   input  logic [8:0]               csr_wdata
);
   import baob_pkg::*;

   localparam int Depth  = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW     = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int NS     = 12;
   localparam int DS     = 8;
   localparam int CW     = CoordWidth;
   localparam logic [12:0] MaxW = 13'(MAX_WIDTH);
   localparam logic [12:0] MaxH = 13'(MAX_HEIGHT);

   function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] x, input logic [CW-1:0] y);
      int a;
      a = int'(y) * MAX_WIDTH + int'(x);
      return AW'(a);
   endfunction

   // configuration
   logic [8:0] tex_width_ff, tex_height_ff;
   logic signed [8:0] off_x_ff, off_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tex_width_ff  <= 9'd256;
         tex_height_ff <= 9'd256;
         off_x_ff      <= '0;
         off_y_ff      <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TEX_WIDTH:  tex_width_ff  <= csr_wdata;
            CSR_TEX_HEIGHT: tex_height_ff <= csr_wdata;
            CSR_OFFSET_X:   off_x_ff      <= csr_wdata;
            CSR_OFFSET_Y:   off_y_ff      <= csr_wdata;
            default: ;
         endcase
      end
   end

   // pipeline registers
   ctl_type ctl_ff [NS];
   ctl_type ctl_in;
   logic [31:0] pix1_ff, pix2_ff, rd_ff;
   logic [23:0] nc3_ff, oc3_ff;
   logic [15:0] wn3_ff, wo3_ff, d3_ff;
   logic [31:0] pass3_ff;
   logic [NumWidth-1:0] rem_ff [DS+1][3];
   logic [7:0]          q_ff   [DS+1][3];
   logic [15:0]         d_ff   [DS+1];
   logic [7:0]          a_ff   [DS+1];
   logic [31:0]         pass_ff[DS+1];
   logic [31:0] mem [Depth];

   // entry: placement, clipping, hazard
   logic signed [9:0] sx, sy;
   logic [12:0] w_eff, h_eff;
   logic inb, hit;

   always_comb begin
      w_eff = ({4'b0, tex_width_ff}  < MaxW) ? {4'b0, tex_width_ff}  : MaxW;
      h_eff = ({4'b0, tex_height_ff} < MaxH) ? {4'b0, tex_height_ff} : MaxH;
      if (act_type'(req_data.action) == ACT_BLEND) begin
         sx = 10'(off_x_ff) + $signed({2'b0, req_data.pos_x});
         sy = 10'(off_y_ff) + $signed({2'b0, req_data.pos_y});
      end else begin
         sx = $signed({2'b0, req_data.pos_x});
         sy = $signed({2'b0, req_data.pos_y});
      end
      inb = !sx[9] && !sy[9] && ({4'b0, sx[8:0]} < w_eff) && ({4'b0, sy[8:0]} < h_eff);
      ctl_in.vld = inb && (act_type'(req_data.action) != ACT_NONE);
      ctl_in.act = act_type'(req_data.action);
      ctl_in.x   = sx[8:0];
      ctl_in.y   = sy[8:0];
      hit = 1'b0;
      for (int i = 0; i < NS; i++) begin
         if (ctl_ff[i].vld && ctl_ff[i].act != ACT_READ &&
             ctl_ff[i].x == ctl_in.x && ctl_ff[i].y == ctl_in.y)
            hit = 1'b1;
      end
      // only reads of the store care; loads write back in order
      busy = hit && ctl_in.vld && ctl_in.act != ACT_LOAD;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NS; i++) ctl_ff[i].vld <= 1'b0;
      end else begin
         ctl_ff[0] <= '{vld: ctl_in.vld && start && !busy, act: ctl_in.act,
                        x: ctl_in.x, y: ctl_in.y};
         for (int i = 1; i < NS; i++) ctl_ff[i] <= ctl_ff[i-1];
      end
   end

   // stage 1: store read
   always_ff @(posedge clock) begin
      if (start && !busy) begin
         pix1_ff <= {req_data.in_alpha, req_data.in_blue, req_data.in_green, req_data.in_red};
      end
      rd_ff   <= mem[addr_of(ctl_ff[0].x, ctl_ff[0].y)];
      pix2_ff <= pix1_ff;
   end

   // stage 2: weights
   logic [7:0] na2, oa2;
   logic [15:0] wn2, wo2;
   always_comb begin
      na2 = pix2_ff[31:24];
      oa2 = rd_ff[31:24];
      wn2 = {na2, 8'b0} - {8'b0, na2};
      wo2 = oa2 * (8'd255 - na2);
   end

   always_ff @(posedge clock) begin
      nc3_ff   <= pix2_ff[23:0];
      oc3_ff   <= rd_ff[23:0];
      wn3_ff   <= wn2;
      wo3_ff   <= wo2;
      d3_ff    <= wn2 + wo2;
      pass3_ff <= (ctl_ff[1].act == ACT_LOAD) ? pix2_ff : rd_ff;
   end

   // stage 3: numerators and alpha (d/255 by reciprocal trick, exact below 65535)
   logic [NumWidth-1:0] num3 [3];
   logic [16:0] a_sum3;
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         num3[c] = NumWidth'(nc3_ff[c*8 +: 8]) * NumWidth'(wn3_ff)
                 + NumWidth'(oc3_ff[c*8 +: 8]) * NumWidth'(wo3_ff);
      end
      a_sum3 = {1'b0, d3_ff} + 17'd1 + {9'b0, d3_ff[15:8]};
   end

   always_ff @(posedge clock) begin
      for (int c = 0; c < 3; c++) begin
         rem_ff[0][c] <= num3[c];
         q_ff[0][c]   <= '0;
      end
      d_ff[0]    <= d3_ff;
      a_ff[0]    <= a_sum3[15:8];
      pass_ff[0] <= pass3_ff;
   end

   // divider: one quotient bit per stage, MSB first
   for (genvar j = 0; j < DS; j++) begin : g_div
      logic [NumWidth-1:0] dsh;
      logic [NumWidth-1:0] rem_in [3];
      logic [7:0]          q_in   [3];
      always_comb begin
         dsh = NumWidth'({d_ff[j], 7'b0} >> j);
         for (int c = 0; c < 3; c++) begin
            q_in[c] = q_ff[j][c];
            if (rem_ff[j][c] >= dsh) begin
               rem_in[c]        = rem_ff[j][c] - dsh;
               q_in[c][DS-1-j]  = 1'b1;
            end else begin
               rem_in[c] = rem_ff[j][c];
            end
         end
      end
      always_ff @(posedge clock) begin
         for (int c = 0; c < 3; c++) begin
            rem_ff[j+1][c] <= rem_in[c];
            q_ff[j+1][c]   <= q_in[c];
         end
         d_ff[j+1]    <= d_ff[j];
         a_ff[j+1]    <= a_ff[j];
         pass_ff[j+1] <= pass_ff[j];
      end
   end

   // final: write back and respond
   ctl_type     fin;
   logic [31:0] res;
   always_comb begin
      fin = ctl_ff[NS-1];
      if (fin.act == ACT_BLEND) begin
         res = (d_ff[DS] == '0) ? 32'b0 :
               {a_ff[DS], q_ff[DS][2], q_ff[DS][1], q_ff[DS][0]};
      end else begin
         res = pass_ff[DS];
      end
   end

   always_ff @(posedge clock) begin
      if (fin.vld && fin.act != ACT_READ) begin
         mem[addr_of(fin.x, fin.y)] <= res;
      end
   end

   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= fin.vld && (fin.act == ACT_BLEND || fin.act == ACT_READ);
      end
      rsp_data_ff <= '{out_x: fin.x[7:0], out_y: fin.y[7:0], out_red: res[7:0],
                       out_green: res[15:8], out_blue: res[23:16], out_alpha: res[31:24]};
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   logic clash0;
   always_comb begin
      clash0 = 1'b0;
      for (int i = 1; i < NS; i++) begin
         if (ctl_ff[i].vld && ctl_ff[i].act != ACT_READ &&
             ctl_ff[i].x == ctl_ff[0].x && ctl_ff[i].y == ctl_ff[0].y)
            clash0 = 1'b1;
      end
   end

   a_no_stale_read: assert property (@(posedge clock) disable iff (reset)
      ctl_ff[0].vld && ctl_ff[0].act != ACT_LOAD |-> !clash0)
      else $error("store read overtakes a pending write");

   a_busy_needs_work: assert property (@(posedge clock) disable iff (reset)
      busy |-> hit)
      else $error("busy without a pipeline hit");

   a_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result strobe right after reset");

   a_rsp_from_pipe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(ctl_ff[NS-1].vld))
      else $error("result with no item in last stage");
`endif

endmodule
